FILE: rtl/cpi_pkg.sv
// Shared types and constants for the OFDM cyclic prefix inserter.
// No dependencies; cpi_regs, cpi_ctrl and the top level import this package.
package cpi_pkg;

  localparam int MAX_SYMBOL  = 2048;
  localparam int SAMPLE_BITS = 32;

  localparam int CFG_W   = 12;
  localparam int ADDR_W  = $clog2(2 * MAX_SYMBOL);
  localparam int SADDR_W = $clog2(MAX_SYMBOL);
  localparam int WPOS_W  = $clog2(MAX_SYMBOL);
  localparam int RPOS_W  = $clog2(2 * MAX_SYMBOL);
  localparam int LEN_W   = $clog2(MAX_SYMBOL) + 1;
  localparam int SLOT_W  = 3;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [SLOT_W-1:0] SLOT_SIZE_EQUAL = SLOT_W'(6);
  localparam logic [SLOT_W-1:0] SLOT_SIZE_MIXED = SLOT_W'(7);

  localparam logic [1:0] REG_SYMBOL_LENGTH       = 2'd0;
  localparam logic [1:0] REG_PREFIX_LENGTH       = 2'd1;
  localparam logic [1:0] REG_FIRST_PREFIX_LENGTH = 2'd2;

  localparam logic [CFG_W-1:0] RST_SYMBOL_LENGTH = CFG_W'(2048);
  localparam logic [CFG_W-1:0] RST_PREFIX_LENGTH = CFG_W'(144);

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_PULL = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] in_sample;
  } req_t;

  typedef struct packed {
    logic [31:0] out_sample;
    logic        out_valid;
    logic        symbol_start;
    logic        symbol_end;
    logic        push_dropped;
  } res_t;

  typedef struct packed {
    logic [CFG_W-1:0] symbol_length;
    logic [CFG_W-1:0] prefix_length;
    logic [CFG_W-1:0] first_prefix_length;
  } cfg_t;

  typedef struct packed {
    logic                   we;
    logic                   re;
    logic [ADDR_W-1:0]      addr;
    logic [SAMPLE_BITS-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic out_valid;
    logic symbol_start;
    logic symbol_end;
    logic push_dropped;
  } res_flags_t;

endpackage

FILE: rtl/cpi_ram.sv
// Single-port synchronous RAM with registered read data.
// Generic; no package dependency.
module cpi_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: rtl/cpi_regs.sv
// APB configuration registers: symbol length and the two prefix lengths.
// Depends on cpi_pkg.
module cpi_regs
  import cpi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.symbol_length       <= RST_SYMBOL_LENGTH;
      cfg.prefix_length       <= RST_PREFIX_LENGTH;
      cfg.first_prefix_length <= RST_PREFIX_LENGTH;
    end else if (wr) begin
      case (idx)
        REG_SYMBOL_LENGTH:       cfg.symbol_length       <= pwdata[CFG_W-1:0];
        REG_PREFIX_LENGTH:       cfg.prefix_length       <= pwdata[CFG_W-1:0];
        REG_FIRST_PREFIX_LENGTH: cfg.first_prefix_length <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SYMBOL_LENGTH:       prdata = PDATA_W'(cfg.symbol_length);
      REG_PREFIX_LENGTH:       prdata = PDATA_W'(cfg.prefix_length);
      REG_FIRST_PREFIX_LENGTH: prdata = PDATA_W'(cfg.first_prefix_length);
      default:                 prdata = '0;
    endcase
  end

endmodule

FILE: rtl/cpi_ctrl.sv
// Bank and position control: turns each request into result flags and, when served, a RAM access.
// Depends on cpi_pkg.
module cpi_ctrl
  import cpi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  req_t       req,
  input  cfg_t       cfg,
  output mem_req_t   mem,
  output res_flags_t flags
);

  logic              write_bank, write_bank_next;
  logic [WPOS_W-1:0] write_position, write_position_next;
  logic [1:0]        bank_full, bank_full_next;
  logic              read_bank, read_bank_next;
  logic [RPOS_W-1:0] read_position, read_position_next;
  logic [SLOT_W-1:0] slot_count, slot_count_next;

  logic [LEN_W-1:0]   n;
  logic [CFG_W-1:0]   cp_raw;
  logic [LEN_W-1:0]   cp;
  logic [LEN_W:0]     total;
  logic [LEN_W:0]     pos_ext;
  logic [LEN_W:0]     addr_calc;
  logic [WPOS_W:0]    wp_inc;
  logic [SLOT_W-1:0]  slot_inc;
  logic [SLOT_W-1:0]  slot_size;
  logic               is_end;

  // effective symbol length: zero reads as one, saturate at the bank size
  always_comb begin
    if (cfg.symbol_length == '0) begin
      n = LEN_W'(1);
    end else if (32'(cfg.symbol_length) > 32'(MAX_SYMBOL)) begin
      n = LEN_W'(MAX_SYMBOL);
    end else begin
      n = LEN_W'(cfg.symbol_length);
    end
  end

  assign cp_raw    = (slot_count == '0) ? cfg.first_prefix_length : cfg.prefix_length;
  assign cp        = (32'(cp_raw) > 32'(n)) ? n : LEN_W'(cp_raw);
  assign total     = (LEN_W+1)'(n) + (LEN_W+1)'(cp);
  assign pos_ext   = (LEN_W+1)'(read_position);
  assign is_end    = pos_ext >= total - (LEN_W+1)'(1);
  assign wp_inc    = (WPOS_W+1)'(write_position) + (WPOS_W+1)'(1);
  assign slot_inc  = slot_count + SLOT_W'(1);
  assign slot_size = (cfg.prefix_length == cfg.first_prefix_length) ?
                     SLOT_SIZE_EQUAL : SLOT_SIZE_MIXED;

  // symbol address: tail of the symbol for the prefix, then the body
  always_comb begin
    if (is_end) begin
      addr_calc = (LEN_W+1)'(n) - (LEN_W+1)'(1);
    end else if (pos_ext < (LEN_W+1)'(cp)) begin
      addr_calc = (LEN_W+1)'(n) - (LEN_W+1)'(cp) + pos_ext;
    end else begin
      addr_calc = pos_ext - (LEN_W+1)'(cp);
    end
  end

  always_comb begin
    write_bank_next     = write_bank;
    write_position_next = write_position;
    bank_full_next      = bank_full;
    read_bank_next      = read_bank;
    read_position_next  = read_position;
    slot_count_next     = slot_count;
    mem                 = '0;
    flags               = '0;
    mem.wdata           = SAMPLE_BITS'(req.in_sample);
    if (accept) begin
      case (req.kind)
        KIND_PUSH: begin
          if (bank_full[write_bank]) begin
            flags.push_dropped = 1'b1;
          end else begin
            mem.we   = 1'b1;
            mem.addr = {write_bank, SADDR_W'(write_position)};
            if (32'(wp_inc) >= 32'(n)) begin
              write_position_next        = '0;
              bank_full_next[write_bank] = 1'b1;
              write_bank_next            = ~write_bank;
            end else begin
              write_position_next = wp_inc[WPOS_W-1:0];
            end
          end
        end
        KIND_PULL: begin
          if (bank_full[read_bank]) begin
            mem.re             = 1'b1;
            mem.addr           = {read_bank, addr_calc[SADDR_W-1:0]};
            flags.out_valid    = 1'b1;
            flags.symbol_start = (read_position == '0);
            flags.symbol_end   = is_end;
            if (is_end) begin
              read_position_next        = '0;
              bank_full_next[read_bank] = 1'b0;
              read_bank_next            = ~read_bank;
              slot_count_next           = (slot_inc >= slot_size) ? '0 : slot_inc;
            end else begin
              read_position_next = read_position + RPOS_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_bank     <= 1'b0;
      write_position <= '0;
      bank_full      <= '0;
      read_bank      <= 1'b0;
      read_position  <= '0;
      slot_count     <= '0;
    end else begin
      write_bank     <= write_bank_next;
      write_position <= write_position_next;
      bank_full      <= bank_full_next;
      read_bank      <= read_bank_next;
      read_position  <= read_position_next;
      slot_count     <= slot_count_next;
    end
  end

endmodule

FILE: rtl/ofdm_cyclic_prefix_inserter_top.sv
// Channel   Signals                      Payload
// request   req_valid / req_ready        req (req_t: kind, in_sample)
// result    res_valid / res_ready        res (res_t: sample and flags)
// config    psel penable pwrite paddr    pwdata / prdata, pready tied high
//
// Every request yields one result on the port: the RAM read data and the stage flags
// register at the accepting edge, the output register when the stage advances.
// One request per clock is sustained while results are taken.
// Reset clears banks-full, positions and slot count; no RAM clearing pass.
// A stalled result holds the RAM stage; request ready drops only then.
// Top level; depends on cpi_pkg, cpi_regs, cpi_ctrl and cpi_ram.
module ofdm_cyclic_prefix_inserter_top
  import cpi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  req_t               req,
  output logic               res_valid,
  input  logic               res_ready,
  output res_t               res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t                   cfg;
  mem_req_t               mem;
  res_flags_t             flags;
  res_flags_t             p1_flags;
  logic                   p1_valid;
  logic                   advance;
  logic                   accept;
  logic [SAMPLE_BITS-1:0] rdata;

  assign advance   = p1_valid && (!res_valid || res_ready);
  assign req_ready = !p1_valid || advance;
  assign accept    = req_valid && req_ready;

  cpi_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cpi_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .cfg    (cfg),
    .mem    (mem),
    .flags  (flags)
  );

  // banks never read and written at once: a bank is written only while not full
  cpi_ram #(
    .DEPTH (2 * MAX_SYMBOL),
    .WIDTH (SAMPLE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .re    (mem.re),
    .addr  (mem.addr),
    .wdata (mem.wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (accept) begin
      p1_valid <= 1'b1;
    end else if (advance) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_flags <= flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.out_sample   <= p1_flags.out_valid ? 32'(rdata) : '0;
      res.out_valid    <= p1_flags.out_valid;
      res.symbol_start <= p1_flags.symbol_start;
      res.symbol_end   <= p1_flags.symbol_end;
      res.push_dropped <= p1_flags.push_dropped;
    end
  end

  a_ready_low_only_when_held: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (p1_valid && res_valid && !res_ready))
    else $error("request ready low without a stalled result");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> p1_valid)
    else $error("accepted request lost before the RAM stage");

  a_single_ram_access: assert property (@(posedge clk) disable iff (rst)
    mem.we |-> !mem.re)
    else $error("RAM read and write in the same cycle");

  a_result_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.push_dropped && res.out_valid))
    else $error("result both dropped and valid");

endmodule
